[src/co2r_pkg.sv]
// Shared constants, types and helpers for the CO2 sensor frame receiver.
`default_nettype none

package co2r_pkg;

  // Frame bytes and markers
  localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
  localparam logic [7:0]  DEF_EXP_CMD    = 8'h86;
  localparam logic [7:0]  STARTUP_STATUS = 8'h3A;
  localparam logic [15:0] NO_VALUE       = 16'hFFFF;

  // Tail positions (position of the byte once counted)
  localparam logic [3:0] POS_CMD      = 4'd1;
  localparam logic [3:0] POS_PPM_HI   = 4'd2;
  localparam logic [3:0] POS_PPM_LO   = 4'd3;
  localparam logic [3:0] POS_STATUS   = 4'd6;
  localparam logic [3:0] POS_LAST_SUM = 4'd7;

  // Multiple-of-125 test: x * inv(125) mod 2^13 <= floor(8191 / 125)
  localparam logic [12:0] INV125   = 13'd6357;
  localparam logic [12:0] MAX_Q125 = 13'd65;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_CMD = 2'd1,
    ST_BAD_SUM = 2'd2,
    ST_STARTUP = 2'd3
  } frame_status_t;

  typedef enum logic {
    CFG_RANGE_EN = 1'b0,
    CFG_EXP_CMD  = 1'b1
  } cfg_index_t;

  // Parser result toward the output register
  typedef struct packed {
    logic          emit;
    logic [15:0]   ppm;
    frame_status_t status;
    logic [15:0]   range_max;
  } parse_result_t;

  // True when v is a nonzero multiple of 1000 (8 * 125)
  function automatic logic is_range_step(input logic [15:0] v);
    logic [12:0] q;
    q = v[15:3] * INV125;
    return (v != 16'd0) && (v[2:0] == 3'd0) && (q <= MAX_Q125);
  endfunction

endpackage

`default_nettype wire

[src/co2_sensor_frame_receiver.sv]
// A checksum byte reaches m_tvalid via the input and output registers.
// Throughput: one byte per cycle; only a result held by m_tready stalls input.
// Each byte is registered, parsed in one pass, and any result lands in the
// output register. Reset (rst, synchronous) clears frame state, empties both
// stages, sets range to 0xFFFF, tracking enabled, expected command 0x86.
`default_nettype none

module co2_sensor_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [15:0] ppm, [17:16] frame_status,
                                      // [33:18] range_max, [39:34] zero
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  logic                      range_tracking_enable;
  logic [7:0]                expected_command;
  logic                      in_valid;
  logic [7:0]                in_byte;
  logic                      fire;
  co2r_pkg::parse_result_t   res;
  logic [15:0]               out_ppm;
  co2r_pkg::frame_status_t   out_status;
  logic [15:0]               out_range;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_tracking_enable <= 1'b1;
      expected_command      <= co2r_pkg::DEF_EXP_CMD;
    end else if (cfg_we) begin
      unique case (co2r_pkg::cfg_index_t'(cfg_index))
        co2r_pkg::CFG_RANGE_EN: range_tracking_enable <= cfg_wdata[0];
        co2r_pkg::CFG_EXP_CMD:  expected_command      <= cfg_wdata;
      endcase
    end
  end

  // Parse stage advances unless a result would overwrite a waiting one
  assign fire     = in_valid && (!res.emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  co2r_parser u_parser (
    .clk                   (clk),
    .rst                   (rst),
    .fire                  (fire),
    .rx_byte               (in_byte),
    .range_tracking_enable (range_tracking_enable),
    .expected_command      (expected_command),
    .res                   (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && res.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      out_ppm    <= res.ppm;
      out_status <= res.status;
      out_range  <= res.range_max;
    end
  end

  assign m_tdata = {6'd0, out_range, out_status, out_ppm};

  // Any error or startup frame carries no reading
  a_no_reading: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status != co2r_pkg::ST_OK |-> out_ppm == co2r_pkg::NO_VALUE)
    else $error("non-ok result carries a reading");

  // A parsed frame end always shows up at the output
  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    fire && res.emit |=> m_tvalid)
    else $error("frame result lost");

  // A stalled input stage keeps its byte
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_byte))
    else $error("stalled input byte changed");

endmodule

`default_nettype wire

[src/co2r_parser.sv]
// Frame state tracker, checksum and result decision for the CO2 receiver.
`default_nettype none

module co2r_parser (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   fire,
  input  wire logic [7:0]             rx_byte,
  input  wire logic                   range_tracking_enable,
  input  wire logic [7:0]             expected_command,
  output co2r_pkg::parse_result_t     res
);

  logic        in_frame;
  logic [3:0]  byte_position;
  logic [7:0]  sum_accumulator;
  logic [7:0]  command_seen;
  logic [15:0] raw_reading;
  logic [7:0]  status_seen;
  logic [15:0] range_value;

  logic [3:0]  pos_inc;
  logic [7:0]  sum_neg;
  logic        range_hit;
  logic [15:0] range_next;

  assign pos_inc = byte_position + 4'd1;
  assign sum_neg = 8'd0 - sum_accumulator;

  // Result decision for the checksum byte
  always_comb begin
    res.emit      = in_frame && (byte_position == co2r_pkg::POS_LAST_SUM);
    res.ppm       = co2r_pkg::NO_VALUE;
    res.status    = co2r_pkg::ST_OK;
    range_hit     = 1'b0;
    if (command_seen != expected_command) begin
      res.status = co2r_pkg::ST_BAD_CMD;
    end else if (sum_neg != rx_byte) begin
      res.status = co2r_pkg::ST_BAD_SUM;
    end else if (status_seen == co2r_pkg::STARTUP_STATUS) begin
      res.status = co2r_pkg::ST_STARTUP;
      range_hit  = range_tracking_enable && co2r_pkg::is_range_step(raw_reading)
                   && (raw_reading != range_value);
    end else begin
      res.ppm = raw_reading;
    end
    range_next    = range_hit ? raw_reading : range_value;
    res.range_max = range_next;
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      byte_position   <= 4'd0;
      sum_accumulator <= 8'd0;
      command_seen    <= 8'd0;
      raw_reading     <= 16'd0;
      status_seen     <= 8'd0;
      range_value     <= co2r_pkg::NO_VALUE;
    end else if (fire) begin
      if (!in_frame) begin
        if (rx_byte == co2r_pkg::SYNC_BYTE) begin
          in_frame        <= 1'b1;
          byte_position   <= 4'd0;
          sum_accumulator <= 8'd0;
        end
      end else if (res.emit) begin
        in_frame      <= 1'b0;
        byte_position <= 4'd0;
        range_value   <= range_next;
      end else begin
        byte_position   <= pos_inc;
        sum_accumulator <= sum_accumulator + rx_byte;
        case (pos_inc)
          co2r_pkg::POS_CMD:    command_seen       <= rx_byte;
          co2r_pkg::POS_PPM_HI: raw_reading[15:8]  <= rx_byte;
          co2r_pkg::POS_PPM_LO: raw_reading[7:0]   <= rx_byte;
          co2r_pkg::POS_STATUS: status_seen        <= rx_byte;
          default: ;
        endcase
      end
    end
  end

  // Position never runs past the checksum byte
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= co2r_pkg::POS_LAST_SUM)
    else $error("byte position past frame end");

  // Idle parser holds position at zero
  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> byte_position == 4'd0)
    else $error("idle with nonzero position");

  // Sync byte while idle opens a clean frame
  a_sync_open: assert property (@(posedge clk) disable iff (rst)
    fire && !in_frame && rx_byte == co2r_pkg::SYNC_BYTE
    |=> in_frame && byte_position == 4'd0 && sum_accumulator == 8'd0)
    else $error("sync byte did not open frame");

endmodule

`default_nettype wire

[tb/sv/co2_sensor_frame_receiver_tb.sv]
// Self-checking testbench for the CO2 sensor frame receiver.
`timescale 1ns / 1ps

module co2_sensor_frame_receiver_tb;
  import co2r_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned RANGE_STEP   = 1000;
  localparam int          TAIL_BYTES   = 8;
  localparam int          RESULT_DELAY = 4;   // output latency plus margin
  localparam int          PHASE_BYTES  = 380;

  // One frame result as carried on m_tdata
  typedef struct packed {
    logic [15:0]   ppm;
    frame_status_t status;
    logic [15:0]   range_max;
  } frame_result_t;

  // Tracks the parser state and the frame results still due from the block
  class co2_frame_scoreboard;
    bit            track_en;
    logic [7:0]    exp_cmd;
    bit            in_frame;
    logic [3:0]    pos;
    logic [7:0]    sum;
    logic [7:0]    cmd_seen;
    logic [15:0]   reading;
    logic [7:0]    stat_seen;
    logic [15:0]   range_val;
    frame_result_t due_q[$];
    int            mismatches;
    int            reports;

    function new();
      track_en   = 1'b1;
      exp_cmd    = DEF_EXP_CMD;
      in_frame   = 1'b0;
      pos        = '0;
      sum        = '0;
      cmd_seen   = '0;
      reading    = '0;
      stat_seen  = '0;
      range_val  = NO_VALUE;
      mismatches = 0;
      reports    = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [7:0] v);
      if (idx == CFG_RANGE_EN) track_en = v[0];
      else exp_cmd = v;
    endfunction

    // Accepted input transaction: advance the parser, queue a result at frame end
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      logic [7:0]    neg_sum;
      if (!in_frame) begin
        if (b == SYNC_BYTE) begin
          in_frame = 1'b1;
          pos      = '0;
          sum      = '0;
        end
        return;
      end
      pos = pos + 4'd1;
      if (pos <= POS_LAST_SUM) begin
        sum = sum + b;
        case (pos)
          POS_CMD:    cmd_seen = b;
          POS_PPM_HI: reading[15:8] = b;
          POS_PPM_LO: reading[7:0] = b;
          POS_STATUS: stat_seen = b;
          default: ;
        endcase
        return;
      end
      // checksum byte closes the frame
      in_frame = 1'b0;
      pos      = '0;
      neg_sum  = 8'd0 - sum;
      r.ppm    = NO_VALUE;
      if (cmd_seen != exp_cmd) begin
        r.status = ST_BAD_CMD;
      end else if (neg_sum != b) begin
        r.status = ST_BAD_SUM;
      end else if (stat_seen == STARTUP_STATUS) begin
        r.status = ST_STARTUP;
        if (track_en && reading != 16'd0 && (reading % RANGE_STEP) == 0 &&
            reading != range_val)
          range_val = reading;
      end else begin
        r.status = ST_OK;
        r.ppm    = reading;
      end
      r.range_max = range_val;
      due_q.push_back(r);
    endfunction

    // Accepted output transaction: compare against the oldest due result
    function void check_result(logic [39:0] d);
      frame_result_t got;
      frame_result_t want;
      got.ppm       = d[15:0];
      got.status    = frame_status_t'(d[17:16]);
      got.range_max = d[33:18];
      if (due_q.size() == 0) begin
        mismatches++;
        if (reports < 10)
          $display("unexpected result: ppm=%h status=%0d range=%h",
                   got.ppm, got.status, got.range_max);
        reports++;
        return;
      end
      want = due_q.pop_front();
      if (got != want) begin
        mismatches++;
        if (reports < 10)
          $display("mismatch: exp ppm=%h status=%0d range=%h, got ppm=%h status=%0d range=%h",
                   want.ppm, want.status, want.range_max,
                   got.ppm, got.status, got.range_max);
        reports++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function int failures();
      return mismatches + due_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;

  co2_frame_scoreboard sb;
  int unsigned         cycle_count;
  int                  burst_left;
  int                  frame_bytes_sent;

  co2_sensor_frame_receiver u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit and receiver stall pattern (mode chosen by cycle_count[9:8])
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    case (cycle_count[9:8])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= ($urandom_range(0, 1) == 0);
      2'd2:    m_tready <= ($urandom_range(0, 5) == 0);
      default: m_tready <= (cycle_count[2:0] != 3'd0);
    endcase
  end

  // Monitor both streams
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
    end
  end

  // Drive one byte; bursts of random length separated by random gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // some long stretches without gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold the sender until every due result has been seen
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (RESULT_DELAY) @(posedge clk);
  endtask

  // Drain and complete any open frame so the parser sits idle
  task automatic settle();
    int n;
    drain();
    if (sb.in_frame) begin
      n = TAIL_BYTES - int'(sb.pos);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      frame_bytes_sent += n;
      drain();
    end
  endtask

  // One register write; the enable drops before the next write
  task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Build a frame and send its first n bytes (n = 9 for a whole frame)
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] value,
                            input logic [7:0] stat, input bit good_sum,
                            input logic [7:0] pad, input int n);
    logic [7:0] fr [9];
    logic [7:0] acc;
    fr[0] = SYNC_BYTE;
    fr[1] = cmd;
    fr[2] = value[15:8];
    fr[3] = value[7:0];
    fr[4] = pad;
    fr[5] = 8'($urandom_range(0, 255));
    fr[6] = stat;
    fr[7] = 8'($urandom_range(0, 255));
    acc = '0;
    for (int i = 1; i <= 7; i++) acc = acc + fr[i];
    fr[8] = 8'd0 - acc;
    if (!good_sum) fr[8] = fr[8] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < n; i++) send_byte(fr[i]);
    frame_bytes_sent += n;
  endtask

  // Random frame content, mostly well formed
  task automatic random_frame(input int n);
    logic [7:0]  cmd;
    logic [15:0] value;
    logic [7:0]  stat;
    cmd = ($urandom_range(0, 9) < 8) ? sb.exp_cmd : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0, 1:    value = 16'(RANGE_STEP * $urandom_range(0, 65));
      2:       value = sb.range_val;
      3:       value = 16'd0;
      4:       value = 16'hFFFF;
      5:       value = 16'(RANGE_STEP * $urandom_range(1, 65) + $urandom_range(1, 7));
      default: value = 16'($urandom_range(0, 65535));
    endcase
    stat = ($urandom_range(0, 4) < 2) ? STARTUP_STATUS : 8'($urandom_range(0, 255));
    send_frame(cmd, value, stat, $urandom_range(0, 99) < 85,
               8'($urandom_range(0, 255)), n);
  endtask

  task automatic random_phase(input int nbytes);
    int target;
    int pick;
    target = frame_bytes_sent + nbytes;
    while (frame_bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise between frames
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        random_frame($urandom_range(1, 8));   // truncated frame
      end else if (pick < 16) begin
        drain();
      end else begin
        random_frame(9);
      end
    end
    settle();
  endtask

  initial begin
    sb          = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_RANGE_EN;
    cfg_wdata   = '0;
    cycle_count = 0;
    burst_left  = 0;
    frame_bytes_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle noise, startup frame with 0xFF inside the tail,
    // wrong command with a bad checksum, valid reading of 0xFFFF
    send_byte(8'h00);
    send_byte(8'hFE);
    send_frame(DEF_EXP_CMD, 16'd2000, STARTUP_STATUS, 1'b1, SYNC_BYTE, 9);
    send_frame(8'h00, 16'hFFFF, 8'h00, 1'b0, 8'h00, 9);
    send_frame(DEF_EXP_CMD, 16'hFFFF, 8'h00, 1'b1, 8'hFF, 9);
    settle();

    // Random phases across register settings
    random_phase(PHASE_BYTES);
    write_reg(CFG_RANGE_EN, 8'hFE);
    write_reg(CFG_EXP_CMD, DEF_EXP_CMD);
    random_phase(PHASE_BYTES);
    write_reg(CFG_RANGE_EN, 8'h01);
    write_reg(CFG_EXP_CMD, 8'h00);
    random_phase(PHASE_BYTES);
    write_reg(CFG_RANGE_EN, 8'($urandom_range(0, 255)));
    write_reg(CFG_EXP_CMD, 8'hFF);
    random_phase(PHASE_BYTES);
    write_reg(CFG_RANGE_EN, 8'hFF);
    write_reg(CFG_EXP_CMD, 8'($urandom_range(0, 255)));
    random_phase(PHASE_BYTES / 2);
    write_reg(CFG_RANGE_EN, 8'($urandom_range(0, 255)));
    write_reg(CFG_EXP_CMD, DEF_EXP_CMD);
    random_phase(PHASE_BYTES / 2);

    drain();
    if (sb.failures() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
